// ----- hw/rtl/dsm_pkg.sv -----
// ----------------------------------------------------------------------------
// dsm_pkg
// Shared types and constants for the DMX source merge block.
// ----------------------------------------------------------------------------
package dsm_pkg;
   localparam int MaxSources = 8;
   localparam int Channels   = 512;
   localparam int SlotW      = 4;
   localparam int ChanW      = 9;
   localparam int LvlAddrW   = 12;
   localparam logic [SlotW-1:0] NoSlot = 4'd15;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_TICK  = 2'd1,
      OP_READ  = 2'd2,
      OP_BLACK = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOSPACE = 2'd1,
      ST_NOSRC   = 2'd2
   } status_type;

   localparam logic [2:0] ModeHigh   = 3'd0;
   localparam logic [2:0] ModeLow    = 3'd1;
   localparam logic [2:0] ModeLatest = 3'd2;
   localparam logic [2:0] ModeBackup = 3'd3;
   localparam logic [2:0] ModeFirst  = 3'd4;

   localparam logic CsrMode    = 1'b0;
   localparam logic CsrTimeout = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIND_MATCH,
      S_FIND_FREE,
      S_PUSH_DONE,
      S_SEL_CLEAN,
      S_SEL_PICK,
      S_MERGE_ADDR,
      S_MERGE_ACC,
      S_COUNT,
      S_RESP
   } state_type;

   typedef struct packed {
      op_type            op;
      logic [31:0]       source_addr;
      logic [1:0]        source_kind;
      logic [ChanW-1:0]  channel;
      logic [7:0]        level;
      logic              frame_end;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  merged_level;
      logic        src_live;
      logic [3:0]  src_count;
   } rsp_type;
endpackage

// ----- hw/rtl/dsm_if.sv -----
// ----------------------------------------------------------------------------
// dsm_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface dsm_if #(parameter type PAYLOAD_TYPE = logic);
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/dmx_source_merge.sv -----
// ----------------------------------------------------------------------------
// dmx_source_merge
// Merges up to eight DMX sources of one port under a configurable mode.
// ----------------------------------------------------------------------------
// Each operation walks the slots in use, one slot per cycle, before rsp goes valid:
// tick/blackout count the active slots, push on channel 0 first seeks a matching or
// free slot, and read on channel 0 first cleans and picks, merging in highest/lowest mode.
// Throughput: one item at a time; req ready only while idle with no response held,
// so the next item is taken only after the response has been accepted.
// Reset is synchronous, active high; it clears slot control state, not level memory.
module dmx_source_merge import dsm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   dsm_if.sink         req,
   dsm_if.source       rsp,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   // configuration
   logic [2:0]  mode_ff;
   logic [15:0] timeout_ff;

   // slot tables
   logic [31:0]      addr_ff  [MaxSources];
   logic [1:0]       kind_ff  [MaxSources];
   logic [MaxSources-1:0] valid_ff;
   logic [31:0]      stamp_ff [MaxSources];
   logic [3:0]       inuse_ff;
   logic [31:0]      tick_ff;
   logic [SlotW-1:0] wslot_ff, prim_ff, chosen_ff;

   // level memory
   logic [7:0] mem [MaxSources*Channels];
   logic [7:0] rdata_ff;

   // sequencer
   state_type        state_ff, state_in;
   req_type          cur_ff;
   logic [SlotW-1:0] idx_ff;
   logic [SlotW-1:0] best_ff;
   logic [31:0]      best_el_ff;
   logic [7:0]       acc_ff;
   logic             found_ff;
   logic [3:0]       cnt_ff;
   rsp_type          out_ff;
   logic             out_v_ff;

   // shared compare unit: is slot idx active, and its elapsed time
   logic [2:0]  ix;
   logic        in_range;
   logic [31:0] elapsed;
   logic        act;
   assign ix       = idx_ff[2:0];
   assign in_range = ({1'b0, idx_ff} < {1'b0, inuse_ff}) && (idx_ff < SlotW'(MaxSources));
   assign elapsed  = tick_ff - stamp_ff[ix];
   assign act      = in_range && valid_ff[ix] && (elapsed <= {16'd0, timeout_ff});

   // activity of the chosen slot, same test
   logic [31:0] ch_el;
   logic        ch_act;
   assign ch_el  = tick_ff - stamp_ff[chosen_ff[2:0]];
   assign ch_act = (chosen_ff < inuse_ff) && (chosen_ff < SlotW'(MaxSources))
                   && valid_ff[chosen_ff[2:0]] && (ch_el <= {16'd0, timeout_ff});

   logic last;
   assign last = ({1'b0, idx_ff} + 5'd1 >= {1'b0, inuse_ff});

   logic [SlotW-1:0] idx_nxt;
   assign idx_nxt = idx_ff + 4'd1;

   // backup helper: primary still active, and the pick including this cycle's slot
   logic [31:0]      pr_el;
   logic             ch_act_prim;
   logic [SlotW-1:0] pick_now;
   assign pr_el       = tick_ff - stamp_ff[prim_ff[2:0]];
   assign ch_act_prim = (prim_ff < inuse_ff) && (prim_ff < SlotW'(MaxSources))
                        && valid_ff[prim_ff[2:0]] && (pr_el <= {16'd0, timeout_ff});
   assign pick_now    = (inuse_ff != '0 && act &&
                         (best_ff == NoSlot ||
                          (mode_ff == ModeLatest && elapsed < best_el_ff)))
                        ? idx_ff : best_ff;

   // flag the first count cycle after a read's merge
   logic prev_merge;

   assign req.ready   = (state_ff == S_IDLE) && !out_v_ff;
   assign rsp.valid   = out_v_ff;
   assign rsp.payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= ModeHigh;
         timeout_ff <= 16'd2500;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrMode:    mode_ff    <= csr_wdata[2:0];
            CsrTimeout: timeout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               unique case (req.payload.op)
                  OP_PUSH:  state_in = (req.payload.channel == '0) ? S_FIND_MATCH
                                                                  : S_PUSH_DONE;
                  OP_READ:  state_in = (req.payload.channel == '0) ? S_SEL_CLEAN
                                                                  : S_MERGE_ADDR;
                  default:  state_in = S_COUNT;
               endcase
            end
         end
         S_FIND_MATCH: begin
            if (inuse_ff == '0) state_in = S_FIND_FREE;
            else if (addr_ff[ix] == cur_ff.source_addr && kind_ff[ix] == cur_ff.source_kind)
               state_in = S_PUSH_DONE;
            else if (last) state_in = S_FIND_FREE;
         end
         S_FIND_FREE: begin
            if (!in_range || !act) state_in = S_PUSH_DONE;
         end
         S_PUSH_DONE:  state_in = S_COUNT;
         S_SEL_CLEAN:  if (inuse_ff == '0 || last) state_in = S_SEL_PICK;
         S_SEL_PICK:   if (inuse_ff == '0 || last) state_in = S_MERGE_ADDR;
         S_MERGE_ADDR: state_in = (mode_ff == ModeHigh || mode_ff == ModeLow)
                                  ? S_MERGE_ACC : S_COUNT;
         S_MERGE_ACC:  if (inuse_ff == '0 || last) state_in = S_COUNT;
         S_COUNT:      if (inuse_ff == '0 || last) state_in = S_RESP;
         S_RESP:       state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   // while accumulating, fetch the next slot's level ahead of its turn
   logic [LvlAddrW-1:0] waddr, raddr;
   assign waddr = {wslot_ff[2:0], cur_ff.channel};
   assign raddr = (state_ff == S_MERGE_ACC) ? {idx_nxt[2:0], cur_ff.channel}
                : (state_ff == S_MERGE_ADDR && !(mode_ff == ModeHigh || mode_ff == ModeLow))
                  ? {chosen_ff[2:0], cur_ff.channel}
                  : {ix, cur_ff.channel};

   // level memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (state_ff == S_PUSH_DONE && wslot_ff < SlotW'(MaxSources))
         mem[waddr] <= cur_ff.level;
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         inuse_ff  <= '0;
         tick_ff   <= '0;
         wslot_ff  <= NoSlot;
         prim_ff   <= NoSlot;
         chosen_ff <= NoSlot;
         out_v_ff  <= 1'b0;
         idx_ff    <= '0;
         for (int i = 0; i < MaxSources; i++) begin
            addr_ff[i]  <= '0;
            kind_ff[i]  <= '0;
            stamp_ff[i] <= '0;
         end
      end else begin
         if (rsp.valid && rsp.ready) out_v_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               idx_ff <= '0;
               if (req.valid && req.ready) begin
                  cur_ff <= req.payload;
                  cnt_ff <= '0;
                  if (req.payload.op == OP_TICK) tick_ff <= tick_ff + 32'd1;
                  if (req.payload.op == OP_BLACK) begin
                     valid_ff <= '0;
                     wslot_ff <= NoSlot;
                  end
               end
            end
            S_FIND_MATCH: begin
               if (inuse_ff == '0) idx_ff <= '0;
               else if (addr_ff[ix] == cur_ff.source_addr
                        && kind_ff[ix] == cur_ff.source_kind)
                  wslot_ff <= idx_ff;
               else if (last) idx_ff <= '0;
               else idx_ff <= idx_ff + 4'd1;
            end
            S_FIND_FREE: begin
               if (in_range && act) idx_ff <= idx_ff + 4'd1;
               else if (in_range || inuse_ff < 4'(MaxSources)) begin
                  // reuse a timed-out slot or open a new one
                  wslot_ff     <= idx_ff;
                  addr_ff[ix]  <= cur_ff.source_addr;
                  kind_ff[ix]  <= cur_ff.source_kind;
                  valid_ff[ix] <= 1'b0;
                  stamp_ff[ix] <= '0;
                  if (!in_range) inuse_ff <= inuse_ff + 4'd1;
               end else wslot_ff <= NoSlot;
            end
            S_PUSH_DONE: begin
               idx_ff <= '0;
               if (wslot_ff >= SlotW'(MaxSources)) begin
                  wslot_ff          <= NoSlot;
                  out_ff.status     <= ST_NOSPACE;
               end else begin
                  out_ff.status <= ST_OK;
                  if (cur_ff.frame_end) begin
                     stamp_ff[wslot_ff[2:0]] <= tick_ff;
                     valid_ff[wslot_ff[2:0]] <= 1'b1;
                     wslot_ff                <= NoSlot;
                  end
               end
               out_ff.merged_level <= '0;
            end
            S_SEL_CLEAN: begin
               if (inuse_ff != '0 && valid_ff[ix] && !act) valid_ff[ix] <= 1'b0;
               idx_ff     <= last ? '0 : idx_ff + 4'd1;
               best_ff    <= NoSlot;
               best_el_ff <= '0;
            end
            S_SEL_PICK: begin
               // first-active or smallest-elapsed scan, one slot per cycle
               if (inuse_ff != '0 && act) begin
                  if (best_ff == NoSlot ||
                      (mode_ff == ModeLatest && elapsed < best_el_ff)) begin
                     best_ff    <= idx_ff;
                     best_el_ff <= elapsed;
                  end
               end
               if (inuse_ff == '0 || last) begin
                  idx_ff <= '0;
                  unique case (mode_ff)
                     ModeHigh, ModeLow: chosen_ff <= NoSlot;
                     ModeBackup: begin
                        if (!ch_act_prim) begin
                           prim_ff   <= pick_now;
                           chosen_ff <= pick_now;
                        end else chosen_ff <= prim_ff;
                     end
                     default: chosen_ff <= pick_now;
                  endcase
               end else idx_ff <= idx_ff + 4'd1;
            end
            S_MERGE_ADDR: begin
               idx_ff   <= '0;
               acc_ff   <= (mode_ff == ModeHigh) ? 8'd0 : 8'd255;
               found_ff <= 1'b0;
            end
            S_MERGE_ACC: begin
               // rdata_ff holds slot idx's level (address issued last cycle)
               if (inuse_ff != '0 && act) begin
                  found_ff <= 1'b1;
                  if (mode_ff == ModeHigh ? (rdata_ff > acc_ff) : (rdata_ff < acc_ff))
                     acc_ff <= rdata_ff;
               end
               idx_ff <= last ? '0 : idx_ff + 4'd1;
            end
            S_COUNT: begin
               if (inuse_ff != '0 && act) cnt_ff <= cnt_ff + 4'd1;
               idx_ff <= last ? '0 : idx_ff + 4'd1;
               if (cur_ff.op == OP_READ && prev_merge) begin
                  if (mode_ff == ModeHigh || mode_ff == ModeLow) begin
                     out_ff.status       <= found_ff ? ST_OK : ST_NOSRC;
                     out_ff.merged_level <= found_ff ? acc_ff : 8'd0;
                  end else begin
                     out_ff.status       <= ch_act ? ST_OK : ST_NOSRC;
                     out_ff.merged_level <= ch_act ? rdata_ff : 8'd0;
                  end
               end else if (cur_ff.op == OP_TICK || cur_ff.op == OP_BLACK) begin
                  out_ff.status       <= ST_OK;
                  out_ff.merged_level <= '0;
               end
            end
            S_RESP: begin
               out_ff.src_count <= cnt_ff;
               out_ff.src_live  <= (cnt_ff != '0);
               out_v_ff         <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // latch merge result once, on the first count cycle after a read
   always_ff @(posedge clock) begin
      if (reset) prev_merge <= 1'b0;
      else       prev_merge <= (state_ff == S_MERGE_ADDR || state_ff == S_MERGE_ACC)
                               && state_in == S_COUNT;
   end
endmodule
